// ===== rtl/json_byte_lexer_core_macros.svh =====
// ----------------------------------------------------------------------------
// json byte lexer assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef JSON_BYTE_LEXER_CORE_MACROS_SVH
`define JSON_BYTE_LEXER_CORE_MACROS_SVH

// same-cycle implication
`define JBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jbl_pkg.sv =====
// ----------------------------------------------------------------------------
// jbl_pkg
// types, codes and byte classifiers for the json byte lexer
// ----------------------------------------------------------------------------
package jbl_pkg;

  localparam int POS_WIDTH_DEF = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam logic [FIFO_AW:0] FIFO_LEVEL_MAX = (FIFO_AW + 1)'(FIFO_DEPTH);
  localparam logic [FIFO_AW:0] FIFO_LEVEL_ROOM = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

  // token kinds
  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_LBRACKET = 4'd1;
  localparam logic [3:0] KIND_RBRACE   = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COLON    = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_NUMBER   = 4'd7;
  localparam logic [3:0] KIND_TRUE     = 4'd8;
  localparam logic [3:0] KIND_FALSE    = 4'd9;
  localparam logic [3:0] KIND_NULL     = 4'd10;
  localparam logic [3:0] KIND_ERROR    = 4'd11;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL = 3'd1;
  localparam logic [2:0] ERR_LITERAL = 3'd2;
  localparam logic [2:0] ERR_NUMBER  = 3'd3;
  localparam logic [2:0] ERR_ESCAPE  = 3'd4;

  // literal selectors
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  // characters
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_POINT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E    = 8'h65;
  localparam logic [7:0] CH_UP_E     = 8'h45;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_A        = 8'h61;
  localparam logic [7:0] CH_B        = 8'h62;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_L        = 8'h6C;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_R        = 8'h72;
  localparam logic [7:0] CH_S        = 8'h73;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_U        = 8'h75;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_NUMBER,
    MODE_LITERAL
  } mode_t;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_MINUS   = 4'd1,
    PH_ZERO    = 4'd2,
    PH_DIGITS  = 4'd3,
    PH_POINT   = 4'd4,
    PH_FRAC    = 4'd5,
    PH_EXP     = 4'd6,
    PH_EXPSIGN = 4'd7,
    PH_EXPDIG  = 4'd8,
    PH_END     = 4'd9,
    PH_BAD     = 4'd15
  } phase_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [2:0]  code;
    logic        last;
  } token_t;

  // results of one byte
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } batch_t;

  typedef struct packed {
    logic               not_empty;
    logic               room;
    logic [FIFO_AW:0]   level;
  } fifo_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_number_end(input logic [7:0] c);
    return is_space(c) || c == CH_RBRACE || c == CH_COMMA || c == CH_RBRACKET;
  endfunction

  function automatic logic escape_ok(input logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B ||
           c == CH_F || c == CH_N || c == CH_R || c == CH_T || c == CH_U;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == CH_LBRACE || c == CH_LBRACKET || c == CH_RBRACE ||
           c == CH_RBRACKET || c == CH_COLON || c == CH_COMMA;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_LBRACE:   k = KIND_LBRACE;
      CH_LBRACKET: k = KIND_LBRACKET;
      CH_RBRACE:   k = KIND_RBRACE;
      CH_RBRACKET: k = KIND_RBRACKET;
      CH_COLON:    k = KIND_COLON;
      default:     k = KIND_COMMA;
    endcase
    return k;
  endfunction

  function automatic phase_t number_next(input phase_t ph, input logic [7:0] c);
    logic   e;
    phase_t nx;
    e  = (c == CH_LOW_E) || (c == CH_UP_E);
    nx = PH_BAD;
    case (ph) inside
      PH_START: begin
        if (c == CH_MINUS) nx = PH_MINUS;
        else if (c == CH_ZERO) nx = PH_ZERO;
        else if (is_digit(c)) nx = PH_DIGITS;
      end
      PH_MINUS: begin
        if (c == CH_ZERO) nx = PH_ZERO;
        else if (is_digit(c)) nx = PH_DIGITS;
      end
      PH_ZERO, PH_DIGITS: begin
        if (c == CH_POINT) nx = PH_POINT;
        else if (e) nx = PH_EXP;
        else if (is_number_end(c)) nx = PH_END;
        else if (ph == PH_DIGITS && is_digit(c)) nx = PH_DIGITS;
      end
      PH_POINT: begin
        if (is_digit(c)) nx = PH_FRAC;
      end
      PH_FRAC: begin
        if (is_digit(c)) nx = PH_FRAC;
        else if (e) nx = PH_EXP;
        else if (is_number_end(c)) nx = PH_END;
      end
      PH_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS) nx = PH_EXPSIGN;
        else if (is_digit(c)) nx = PH_EXPDIG;
      end
      PH_EXPSIGN: begin
        if (is_digit(c)) nx = PH_EXPDIG;
      end
      PH_EXPDIG: begin
        if (is_digit(c)) nx = PH_EXPDIG;
        else if (is_number_end(c)) nx = PH_END;
      end
      default: nx = PH_BAD;
    endcase
    return nx;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [3:0] lit_kind(input logic [1:0] k);
    logic [3:0] r;
    case (k)
      LIT_FALSE: r = KIND_FALSE;
      LIT_NULL:  r = KIND_NULL;
      default:   r = KIND_TRUE;
    endcase
    return r;
  endfunction

  // expected letter of a literal at a given index
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      LIT_FALSE: begin
        case (i)
          3'd0:    ch = CH_F;
          3'd1:    ch = CH_A;
          3'd2:    ch = CH_L;
          3'd3:    ch = CH_S;
          3'd4:    ch = CH_LOW_E;
          default: ch = 8'h00;
        endcase
      end
      LIT_NULL: begin
        case (i)
          3'd0:    ch = CH_N;
          3'd1:    ch = CH_U;
          3'd2:    ch = CH_L;
          3'd3:    ch = CH_L;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (i)
          3'd0:    ch = CH_T;
          3'd1:    ch = CH_R;
          3'd2:    ch = CH_U;
          3'd3:    ch = CH_LOW_E;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/jbl_byte_if.sv =====
// ----------------------------------------------------------------------------
// jbl_byte_if
// document byte channel: valid/ready with one text byte per beat
// ----------------------------------------------------------------------------
interface jbl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_document;

  modport source (output valid, output data_byte, output end_of_document, input ready);
  modport sink (input valid, input data_byte, input end_of_document, output ready);
endinterface

// ===== rtl/jbl_token_if.sv =====
// ----------------------------------------------------------------------------
// jbl_token_if
// token channel: valid/ready with one token per beat
// ----------------------------------------------------------------------------
interface jbl_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [2:0]  error_code;
  logic        run_last;

  modport source (
    output valid, output token_kind, output token_start, output token_length,
    output error_code, output run_last, input ready
  );
  modport sink (
    input valid, input token_kind, input token_start, input token_length,
    input error_code, input run_last, output ready
  );
endinterface

// ===== rtl/json_byte_lexer_core.sv =====
// ----------------------------------------------------------------------------
// json_byte_lexer_core
// byte-serial json tokenizer: braces, brackets, colon, comma, strings,
// numbers and literals with start offset and length, one error per document
// ----------------------------------------------------------------------------
// channel  dir  beat
// text     in   data_byte, end_of_document
// tokens   out  token_kind, token_start, token_length, error_code, run_last
//
// one byte per cycle while the token queue has room; a byte passes the input register
// to the step logic and its tokens are written into the token queue before they are offered
// a byte that ends a number and is a brace, bracket or comma gives two tokens, queued together
// the token queue holds four entries; text stalls while more than two wait
// synchronous reset clears all lexer state at once, no clearing pass
// ----------------------------------------------------------------------------
`include "json_byte_lexer_core_macros.svh"

module json_byte_lexer_core #(
  parameter int POS_WIDTH = jbl_pkg::POS_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  jbl_byte_if.sink    text,
  jbl_token_if.source tokens
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 in_eod;
  logic                 advance;
  jbl_pkg::batch_t      batch;
  jbl_pkg::token_t      head;
  jbl_pkg::fifo_stat_t  fifo_stat;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_byte <= text.data_byte;
      in_eod  <= text.end_of_document;
    end
  end

  assign advance    = in_valid && fifo_stat.room;
  assign text.ready = !in_valid || fifo_stat.room;

  jbl_scan #(
    .POS_WIDTH (POS_WIDTH)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .data_byte       (in_byte),
    .end_of_document (in_eod),
    .batch           (batch)
  );

  jbl_res_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .batch (batch),
    .pop   (tokens.valid && tokens.ready),
    .head  (head),
    .stat  (fifo_stat)
  );

  assign tokens.valid        = fifo_stat.not_empty;
  assign tokens.token_kind   = head.kind;
  assign tokens.token_start  = head.start;
  assign tokens.token_length = head.length;
  assign tokens.error_code   = head.code;
  assign tokens.run_last     = head.last;

  `JBL_ASSERT_NOW(a_level_bound, 1'b1, fifo_stat.level <= jbl_pkg::FIFO_LEVEL_MAX, "token queue overflow")
  `JBL_ASSERT_NOW(a_pair_shape, batch.count == 2'd2, batch.first.kind == jbl_pkg::KIND_NUMBER && !batch.first.last && batch.second.last, "bad token pair")
  `JBL_ASSERT_NOW(a_single_last, batch.count == 2'd1, batch.first.last, "single token without run_last")
  `JBL_ASSERT_NEXT(a_stall_hold, in_valid && !fifo_stat.room, in_valid && $stable(in_byte), "stalled byte lost")

endmodule

// ===== rtl/jbl_scan.sv =====
// ----------------------------------------------------------------------------
// jbl_scan
// lexer state and combinational byte step, up to two tokens per byte
// ----------------------------------------------------------------------------
module jbl_scan #(
  parameter int POS_WIDTH = jbl_pkg::POS_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       data_byte,
  input  logic             end_of_document,
  output jbl_pkg::batch_t  batch
);

  jbl_pkg::mode_t         mode, mode_next;
  jbl_pkg::phase_t        phase, phase_next;
  logic                   esc, esc_next;
  logic [1:0]             lkind, lkind_next;
  logic [2:0]             lidx, lidx_next;
  logic [POS_WIDTH-1:0]   pos, pos_next;
  logic [POS_WIDTH-1:0]   origin, origin_next;
  logic                   sticky, sticky_next;

  jbl_pkg::token_t        res [2];
  logic [1:0]             cnt;
  logic                   do_idle;
  jbl_pkg::phase_t        nx;
  jbl_pkg::phase_t        st;
  logic [2:0]             lidx_inc;
  logic [POS_WIDTH-1:0]   p_inc;

  function automatic logic [15:0] to16(input logic [POS_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic jbl_pkg::token_t mk(input logic [3:0] kind,
                                         input logic [POS_WIDTH-1:0] start,
                                         input logic [POS_WIDTH-1:0] len,
                                         input logic [2:0] code);
    jbl_pkg::token_t t;
    t.kind   = kind;
    t.start  = to16(start);
    t.length = to16(len);
    t.code   = code;
    t.last   = 1'b0;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= jbl_pkg::MODE_IDLE;
      phase  <= jbl_pkg::PH_START;
      esc    <= 1'b0;
      lkind  <= jbl_pkg::LIT_TRUE;
      lidx   <= 3'd0;
      pos    <= '0;
      origin <= '0;
      sticky <= 1'b0;
    end else begin
      mode   <= mode_next;
      phase  <= phase_next;
      esc    <= esc_next;
      lkind  <= lkind_next;
      lidx   <= lidx_next;
      pos    <= pos_next;
      origin <= origin_next;
      sticky <= sticky_next;
    end
  end

  always_comb begin
    mode_next   = mode;
    phase_next  = phase;
    esc_next    = esc;
    lkind_next  = lkind;
    lidx_next   = lidx;
    pos_next    = pos;
    origin_next = origin;
    sticky_next = sticky;
    res[0]      = '0;
    res[1]      = '0;
    cnt         = 2'd0;
    do_idle     = 1'b0;
    nx          = jbl_pkg::number_next(phase, data_byte);
    st          = jbl_pkg::number_next(jbl_pkg::PH_START, data_byte);
    lidx_inc    = lidx + 3'd1;
    p_inc       = pos + POS_WIDTH'(1);

    if (fire && !sticky) begin
      unique case (mode)
        jbl_pkg::MODE_STRING: begin
          if (esc) begin
            if (jbl_pkg::escape_ok(data_byte)) begin
              esc_next = 1'b0;
            end else begin
              res[cnt[0]] = mk(jbl_pkg::KIND_ERROR, pos, '0, jbl_pkg::ERR_ESCAPE);
              cnt = cnt + 2'd1;
              sticky_next = 1'b1;
              mode_next = jbl_pkg::MODE_IDLE;
            end
          end else if (data_byte == jbl_pkg::CH_BSLASH) begin
            esc_next = 1'b1;
          end else if (data_byte == jbl_pkg::CH_QUOTE) begin
            res[cnt[0]] = mk(jbl_pkg::KIND_STRING, origin, pos - origin, jbl_pkg::ERR_NONE);
            cnt = cnt + 2'd1;
            mode_next = jbl_pkg::MODE_IDLE;
          end
        end
        jbl_pkg::MODE_NUMBER: begin
          if (nx == jbl_pkg::PH_BAD) begin
            res[cnt[0]] = mk(jbl_pkg::KIND_ERROR, pos, '0, jbl_pkg::ERR_NUMBER);
            cnt = cnt + 2'd1;
            sticky_next = 1'b1;
            mode_next = jbl_pkg::MODE_IDLE;
          end else if (nx == jbl_pkg::PH_END) begin
            res[cnt[0]] = mk(jbl_pkg::KIND_NUMBER, origin, pos - origin, jbl_pkg::ERR_NONE);
            cnt = cnt + 2'd1;
            mode_next = jbl_pkg::MODE_IDLE;
            phase_next = jbl_pkg::PH_START;
            do_idle = 1'b1;
          end else begin
            phase_next = nx;
          end
        end
        jbl_pkg::MODE_LITERAL: begin
          if (lidx < jbl_pkg::lit_len(lkind) &&
              data_byte == jbl_pkg::lit_char(lkind, lidx)) begin
            lidx_next = lidx_inc;
            if (lidx_inc == jbl_pkg::lit_len(lkind)) begin
              res[cnt[0]] = mk(jbl_pkg::lit_kind(lkind), origin,
                               POS_WIDTH'(jbl_pkg::lit_len(lkind)), jbl_pkg::ERR_NONE);
              cnt = cnt + 2'd1;
              mode_next = jbl_pkg::MODE_IDLE;
            end
          end else begin
            res[cnt[0]] = mk(jbl_pkg::KIND_ERROR, pos, '0, jbl_pkg::ERR_LITERAL);
            cnt = cnt + 2'd1;
            sticky_next = 1'b1;
            mode_next = jbl_pkg::MODE_IDLE;
          end
        end
        jbl_pkg::MODE_IDLE: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_idle && !jbl_pkg::is_space(data_byte)) begin
        if (jbl_pkg::is_punct(data_byte)) begin
          res[cnt[0]] = mk(jbl_pkg::punct_kind(data_byte), pos, POS_WIDTH'(1),
                           jbl_pkg::ERR_NONE);
          cnt = cnt + 2'd1;
        end else if (data_byte == jbl_pkg::CH_QUOTE) begin
          mode_next = jbl_pkg::MODE_STRING;
          esc_next = 1'b0;
          origin_next = p_inc;
        end else if (data_byte == jbl_pkg::CH_T || data_byte == jbl_pkg::CH_F ||
                     data_byte == jbl_pkg::CH_N) begin
          mode_next = jbl_pkg::MODE_LITERAL;
          lkind_next = (data_byte == jbl_pkg::CH_T) ? jbl_pkg::LIT_TRUE :
                       (data_byte == jbl_pkg::CH_F) ? jbl_pkg::LIT_FALSE :
                       jbl_pkg::LIT_NULL;
          lidx_next = 3'd1;
          origin_next = pos;
        end else if (jbl_pkg::is_digit(data_byte) || data_byte == jbl_pkg::CH_MINUS ||
                     data_byte == jbl_pkg::CH_POINT) begin
          origin_next = pos;
          if (st == jbl_pkg::PH_BAD) begin
            res[cnt[0]] = mk(jbl_pkg::KIND_ERROR, pos, '0, jbl_pkg::ERR_NUMBER);
            cnt = cnt + 2'd1;
            sticky_next = 1'b1;
            mode_next = jbl_pkg::MODE_IDLE;
          end else begin
            mode_next = jbl_pkg::MODE_NUMBER;
            phase_next = st;
          end
        end else begin
          res[cnt[0]] = mk(jbl_pkg::KIND_ERROR, pos, '0, jbl_pkg::ERR_ILLEGAL);
          cnt = cnt + 2'd1;
          sticky_next = 1'b1;
          mode_next = jbl_pkg::MODE_IDLE;
        end
      end

      // flush of a pending string or number at end of document; an unfinished literal gives an error
      if (end_of_document && !sticky_next) begin
        unique case (mode_next)
          jbl_pkg::MODE_STRING: begin
            res[cnt[0]] = mk(jbl_pkg::KIND_STRING, origin_next, p_inc - origin_next,
                             jbl_pkg::ERR_NONE);
            cnt = cnt + 2'd1;
          end
          jbl_pkg::MODE_NUMBER: begin
            res[cnt[0]] = mk(jbl_pkg::KIND_NUMBER, origin_next, p_inc - origin_next,
                             jbl_pkg::ERR_NONE);
            cnt = cnt + 2'd1;
          end
          jbl_pkg::MODE_LITERAL: begin
            res[cnt[0]] = mk(jbl_pkg::KIND_ERROR, pos, '0, jbl_pkg::ERR_LITERAL);
            cnt = cnt + 2'd1;
          end
          jbl_pkg::MODE_IDLE: begin
          end
        endcase
      end
    end

    if (cnt == 2'd1) begin
      res[0].last = 1'b1;
    end else if (cnt == 2'd2) begin
      res[1].last = 1'b1;
    end

    if (fire) begin
      if (end_of_document) begin
        mode_next   = jbl_pkg::MODE_IDLE;
        phase_next  = jbl_pkg::PH_START;
        esc_next    = 1'b0;
        lkind_next  = jbl_pkg::LIT_TRUE;
        lidx_next   = 3'd0;
        pos_next    = '0;
        origin_next = '0;
        sticky_next = 1'b0;
      end else begin
        pos_next = p_inc;
      end
    end

    batch.count  = cnt;
    batch.first  = res[0];
    batch.second = res[1];
  end

endmodule

// ===== rtl/jbl_res_fifo.sv =====
// ----------------------------------------------------------------------------
// jbl_res_fifo
// small token queue, takes up to two tokens per cycle and gives one
// ----------------------------------------------------------------------------
module jbl_res_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  jbl_pkg::batch_t      batch,
  input  logic                 pop,
  output jbl_pkg::token_t      head,
  output jbl_pkg::fifo_stat_t  stat
);

  localparam int AW = jbl_pkg::FIFO_AW;

  jbl_pkg::token_t  mem [jbl_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wp, wp_next;
  logic [AW-1:0]    rp, rp_next;
  logic [AW:0]      level, level_next;
  logic [AW-1:0]    wp_inc;

  always_comb begin
    wp_inc     = wp + AW'(1);
    wp_next    = wp + AW'(batch.count);
    rp_next    = rp + AW'(pop);
    level_next = level + (AW + 1)'(batch.count) - (AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp_next;
      rp    <= rp_next;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (batch.count != 2'd0) begin
      mem[wp] <= batch.first;
    end
    if (batch.count == 2'd2) begin
      mem[wp_inc] <= batch.second;
    end
  end

  assign head           = mem[rp];
  assign stat.not_empty = (level != '0);
  assign stat.room      = (level <= jbl_pkg::FIFO_LEVEL_ROOM);
  assign stat.level     = level;

endmodule
